FILE: rtl/core/hpq_pkg.sv
`default_nettype none
package hpq_pkg;

  localparam int unsigned CapBits   = 9;
  localparam int unsigned CountBits = 9;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DELMIN   = 2'd1,
    REQ_DECREASE = 2'd2,
    REQ_QUERY    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_UP_RD   = 10'b0000000010,
    S_UP_CMP  = 10'b0000000100,
    S_DN_ROOT = 10'b0000001000,
    S_DN_LAST = 10'b0000010000,
    S_DN_RD   = 10'b0000100000,
    S_DN_CMP  = 10'b0001000000,
    S_SR_RD   = 10'b0010000000,
    S_SR_CMP  = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } state_e;

  // Access request broadcast to every level cell.
  typedef struct packed {
    logic rd;
    logic we;
    logic wbank;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/min_heap_priority_queue_core.sv
`default_nettype none
// Min-ordered binary heap of (vertex, cost) entries.
// Requests enter on s_axis (insert, delete minimum, decrease cost, query
// empty); each gives one result on m_axis with a status, the removed entry
// and the entry count after the request. cfg_* writes the capacity and is
// always ready; write it only while no request is in flight.
// The heap is a row of level cells, one per tree level, each with an even
// and an odd bank RAM; one level is accessed per cycle.
// Steps per request, before the result register:
//   query, full or empty: straight to the result
//   insert: the entry climbs one level per step while its parent is larger
//   delete minimum: reads the root, then, if entries remain, the last
//     entry, which sinks one level per step while a child is smaller
//   decrease: searches the entries in index order through the match, then
//     climbs as insert; not found once every entry has been searched.
// One request is worked at a time; the next is taken once the previous
// result sits in the output register. A stalled receiver holds that result
// and the block waits at its end with the following one.
// Reset empties the heap and sets the capacity to 256; no clearing pass.
module min_heap_priority_queue_core #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned VERTEX_BITS = 16,
  parameter int unsigned COST_BITS   = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // req_type[1:0], vertex_id, item_cost, zero pad
  input  wire logic [((2+VERTEX_BITS+COST_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // status[1:0], out_vertex, out_cost, entry_count[8:0], zero pad
  output logic [((2+VERTEX_BITS+COST_BITS+hpq_pkg::CountBits+7)/8)*8-1:0] m_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  input  wire logic [hpq_pkg::CapBits-1:0] cfg_data_i,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o
);
  import hpq_pkg::*;

  localparam int unsigned VB     = VERTEX_BITS;
  localparam int unsigned CB     = COST_BITS;
  localparam int unsigned DW     = VB + CB;
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned LVLS   = CW;
  localparam int unsigned LW     = (LVLS > 1) ? $clog2(LVLS) : 1;
  localparam int unsigned RW     = CW - 1;
  localparam int unsigned MW     = (CW > CapBits) ? CW : CapBits;
  localparam int unsigned OUT_W  = 2 + VB + CB + CountBits;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CapBits-1:0] cap_q;
  logic [LW-1:0]    pos_lvl_q, pos_lvl_d;
  logic [CW-1:0]    pos_off_q, pos_off_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [VB-1:0]    cur_v_q, cur_v_d;
  logic [CB-1:0]    cur_c_q, cur_c_d;
  status_e          res_st_q, res_st_d;
  logic [VB-1:0]    res_v_q, res_v_d;
  logic [CB-1:0]    res_c_q, res_c_d;
  logic             rd_bank_q, rd_bank_d;
  logic             m_valid_q;
  logic [OUT_TW-1:0] m_data_q;

  cell_cmd_t        cmd;
  logic [LW-1:0]    cmd_lvl;
  logic [RW-1:0]    cmd_row;
  logic [DW-1:0]    cmd_wdata;

  logic [2*DW-1:0]  rd_chain [LVLS+1];
  logic [2*DW-1:0]  rd_pair;
  logic [DW-1:0]    rd_one;
  logic [DW-1:0]    rd_left, rd_right, child;
  logic             pick;

  logic             s_accept;
  logic [1:0]       in_req;
  logic [VB-1:0]    in_v;
  logic [CB-1:0]    in_c;
  logic             full;
  logic [MW-1:0]    cap_ext, depth_ext, cap_eff;
  logic [LW-1:0]    loc_lvl;
  logic [CW-1:0]    loc_off;
  logic [CW:0]      left_idx;
  logic [CW:0]      off_inc;
  logic             load_out;

  // Level and offset of heap index count_q.
  function automatic logic [LW+CW-1:0] locate(input logic [CW-1:0] idx);
    logic [CW-1:0] p;
    logic [LW-1:0] l;
    p = idx + 1'b1;
    l = '0;
    for (int b = 0; b < CW; b++) begin
      if (p[b]) begin
        l = LW'(b);
      end
    end
    return {l, p ^ (CW'(1) << l)};
  endfunction

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign in_req   = s_axis_tdata[1:0];
  assign in_v     = s_axis_tdata[2 +: VB];
  assign in_c     = s_axis_tdata[2+VB +: CB];

  assign cap_ext   = MW'(cap_q);
  assign depth_ext = MW'(DEPTH);
  assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign full      = MW'(count_q) >= cap_eff;

  assign {loc_lvl, loc_off} = locate(count_q);

  assign rd_chain[LVLS] = '0;
  for (genvar k = 0; k < LVLS; k++) begin : g_level
    localparam int unsigned Span = 2 ** k;
    localparam int unsigned Used = (Span < DEPTH + 1 - Span) ? Span : DEPTH + 1 - Span;
    localparam int unsigned Rows = (k == 0) ? 1 : (Used + 1) / 2;
    hpq_cell #(
      .LEVEL (k),
      .ROWS  (Rows),
      .DW    (DW),
      .LW    (LW),
      .RW    (RW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .lvl_i   (cmd_lvl),
      .row_i   (cmd_row),
      .wdata_i (cmd_wdata),
      .rd_i    (rd_chain[k+1]),
      .rd_o    (rd_chain[k])
    );
  end

  assign rd_pair  = rd_chain[0];
  assign rd_left  = rd_pair[DW-1:0];
  assign rd_right = rd_pair[2*DW-1:DW];
  assign rd_one   = rd_bank_q ? rd_right : rd_left;
  assign left_idx = {idx_q, 1'b1};
  assign pick     = (left_idx < {1'b0, count_q}) && (rd_left[DW-1:VB] > rd_right[DW-1:VB]);
  assign child    = pick ? rd_right : rd_left;
  assign off_inc  = {1'b0, pos_off_q} + 1'b1;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_lvl_d = pos_lvl_q;
    pos_off_d = pos_off_q;
    idx_d     = idx_q;
    cur_v_d   = cur_v_q;
    cur_c_d   = cur_c_q;
    res_st_d  = res_st_q;
    res_v_d   = res_v_q;
    res_c_d   = res_c_q;
    rd_bank_d = rd_bank_q;
    cmd       = '0;
    cmd.wbank = pos_off_q[0];
    cmd_lvl   = pos_lvl_q;
    cmd_row   = RW'(pos_off_q >> 1);
    cmd_wdata = {cur_c_q, cur_v_q};
    load_out  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          res_st_d = ST_OK;
          res_v_d  = '0;
          res_c_d  = '0;
          cur_v_d  = in_v;
          cur_c_d  = in_c;
          case (in_req)
            REQ_INSERT: begin
              if (full) begin
                res_st_d = ST_FULL;
                state_d  = S_FIN;
              end else begin
                pos_lvl_d = loc_lvl;
                pos_off_d = loc_off;
                count_d   = count_q + 1'b1;
                state_d   = S_UP_RD;
              end
            end
            REQ_DELMIN: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_FIN;
              end else begin
                cmd.rd    = 1'b1;
                cmd_lvl   = '0;
                cmd_row   = '0;
                rd_bank_d = 1'b0;
                count_d   = count_q - 1'b1;
                state_d   = S_DN_ROOT;
              end
            end
            REQ_DECREASE: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_FIN;
              end else begin
                pos_lvl_d = '0;
                pos_off_d = '0;
                idx_d     = '0;
                state_d   = S_SR_RD;
              end
            end
            default: begin
              res_st_d = (count_q == '0) ? ST_EMPTY : ST_OK;
              state_d  = S_FIN;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (pos_lvl_q == '0) begin
          cmd.we  = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          cmd_lvl   = pos_lvl_q - 1'b1;
          cmd_row   = RW'(pos_off_q >> 2);
          rd_bank_d = pos_off_q[1];
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.we = 1'b1;
        if (rd_one[DW-1:VB] > cur_c_q) begin
          // Parent moves down into the hole; continue one level up.
          cmd_wdata = rd_one;
          pos_lvl_d = pos_lvl_q - 1'b1;
          pos_off_d = pos_off_q >> 1;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_ROOT: begin
        res_v_d = rd_one[VB-1:0];
        res_c_d = rd_one[DW-1:VB];
        if (count_q == '0) begin
          state_d = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          cmd_lvl   = loc_lvl;
          cmd_row   = RW'(loc_off >> 1);
          rd_bank_d = loc_off[0];
          state_d   = S_DN_LAST;
        end
      end
      S_DN_LAST: begin
        cur_v_d   = rd_one[VB-1:0];
        cur_c_d   = rd_one[DW-1:VB];
        pos_lvl_d = '0;
        pos_off_d = '0;
        idx_d     = '0;
        state_d   = S_DN_RD;
      end
      S_DN_RD: begin
        if (left_idx <= {1'b0, count_q}) begin
          cmd.rd  = 1'b1;
          cmd_lvl = pos_lvl_q + 1'b1;
          cmd_row = RW'(pos_off_q);
          state_d = S_DN_CMP;
        end else begin
          cmd.we  = 1'b1;
          state_d = S_FIN;
        end
      end
      S_DN_CMP: begin
        cmd.we = 1'b1;
        if (child[DW-1:VB] < cur_c_q) begin
          cmd_wdata = child;
          idx_d     = CW'(left_idx + pick);
          pos_lvl_d = pos_lvl_q + 1'b1;
          pos_off_d = CW'({pos_off_q, pick});
          state_d   = S_DN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SR_RD: begin
        if (idx_q == count_q) begin
          res_st_d = ST_NOTFOUND;
          state_d  = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          rd_bank_d = pos_off_q[0];
          state_d   = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        if (rd_one[VB-1:0] == cur_v_q) begin
          state_d = S_UP_RD;
        end else begin
          idx_d = idx_q + 1'b1;
          if (off_inc == ((CW+1)'(1) << pos_lvl_q)) begin
            pos_lvl_d = pos_lvl_q + 1'b1;
            pos_off_d = '0;
          end else begin
            pos_off_d = CW'(off_inc);
          end
          state_d = S_SR_RD;
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cap_q     <= CapBits'(256);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_lvl_q <= pos_lvl_d;
    pos_off_q <= pos_off_d;
    idx_q     <= idx_d;
    cur_v_q   <= cur_v_d;
    cur_c_q   <= cur_c_d;
    res_st_q  <= res_st_d;
    res_v_q   <= res_v_d;
    res_c_q   <= res_c_d;
    rd_bank_q <= rd_bank_d;
    if (load_out) begin
      m_data_q <= OUT_TW'({CountBits'(count_q), res_c_q, res_v_q, res_st_q});
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    MW'(count_q) <= depth_ext) else $error("entry count above depth");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q != S_IDLE)) else $error("accepted request not started");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!m_valid_q || m_axis_tready)) |=> m_valid_q)
    else $error("finished result not presented");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && in_req == REQ_INSERT && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the heap");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/hpq_ram.sv
`default_nettype none
module hpq_ram #(
  parameter int unsigned W = 48,
  parameter int unsigned D = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic                           re_i,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] addr_i,
  input  wire logic [W-1:0]                   wdata_i,
  output logic      [W-1:0]                   rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/core/hpq_cell.sv
`default_nettype none
// One heap level. Offsets are split into an even and an odd bank so that
// both children of a node come out of one read at the same row.
module hpq_cell #(
  parameter int unsigned LEVEL = 0,
  parameter int unsigned ROWS  = 1,
  parameter int unsigned DW    = 48,
  parameter int unsigned LW    = 4,
  parameter int unsigned RW    = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hpq_pkg::cell_cmd_t    cmd_i,
  input  wire logic [LW-1:0]         lvl_i,
  input  wire logic [RW-1:0]         row_i,
  input  wire logic [DW-1:0]         wdata_i,
  input  wire logic [2*DW-1:0]       rd_i,
  output logic      [2*DW-1:0]       rd_o
);
  import hpq_pkg::*;

  localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic          sel;
  logic          sel_q;
  logic [DW-1:0] bank_rd [2];
  logic [AW-1:0] addr;

  assign sel  = (lvl_i == LW'(LEVEL));
  assign addr = AW'(row_i);

  for (genvar b = 0; b < 2; b++) begin : g_bank
    hpq_ram #(.W(DW), .D(ROWS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (sel && cmd_i.we && (cmd_i.wbank == 1'(b))),
      .re_i    (sel && cmd_i.rd),
      .addr_i  (addr),
      .wdata_i (wdata_i),
      .rdata_o (bank_rd[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (cmd_i.rd) begin
      sel_q <= sel;
    end
  end

  // Read data travels down the chain toward level zero.
  assign rd_o = sel_q ? {bank_rd[1], bank_rd[0]} : rd_i;
endmodule
`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  import hpq_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IN_W  = 56;
  localparam int unsigned OUT_W = 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // Listed from the highest bits down, so status lands in the lowest bits.
  typedef struct packed {
    logic [8:0]  count;
    logic [31:0] cost;
    logic [15:0] vertex;
    logic [1:0]  status;
  } heap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [8:0] cfg_data_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;

  min_heap_priority_queue_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_data_i, .cfg_valid_i, .cfg_ready_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow heap that mirrors the block.
  logic [15:0] shadow_vertex [DEPTH];
  logic [31:0] shadow_cost [DEPTH];
  int unsigned shadow_count;
  int unsigned shadow_capacity;
  heap_result_t pending_results[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned inserted_vertices[$];

  function automatic void shadow_sift_up(int unsigned pos, logic [15:0] v, logic [31:0] c);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!(shadow_cost[parent] > c)) break;
      shadow_vertex[pos] = shadow_vertex[parent];
      shadow_cost[pos] = shadow_cost[parent];
      pos = parent;
    end
    shadow_vertex[pos] = v;
    shadow_cost[pos] = c;
  endfunction

  function automatic heap_result_t predict_heap_request(req_e req, logic [15:0] v,
                                                        logic [31:0] c);
    heap_result_t r;
    int unsigned cap, i, n, child;
    logic [15:0] lv;
    logic [31:0] lc;
    r = '0;
    r.status = ST_OK;
    cap = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    case (req)
      REQ_INSERT: begin
        if (shadow_count >= cap) r.status = ST_FULL;
        else begin
          shadow_sift_up(shadow_count, v, c);
          shadow_count++;
        end
      end
      REQ_DELMIN: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          r.vertex = shadow_vertex[0];
          r.cost = shadow_cost[0];
          shadow_count--;
          n = shadow_count;
          lv = shadow_vertex[n];
          lc = shadow_cost[n];
          i = 0;
          while (2 * i + 1 <= n) begin
            child = 2 * i + 1;
            if (child < n && shadow_cost[child] > shadow_cost[child + 1]) child++;
            if (shadow_cost[child] < lc) begin
              shadow_vertex[i] = shadow_vertex[child];
              shadow_cost[i] = shadow_cost[child];
              i = child;
            end else break;
          end
          shadow_vertex[i] = lv;
          shadow_cost[i] = lc;
        end
      end
      REQ_DECREASE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          for (i = 0; i < shadow_count; i++)
            if (shadow_vertex[i] == v) break;
          if (i == shadow_count) r.status = ST_NOTFOUND;
          else shadow_sift_up(i, v, c);
        end
      end
      default: r.status = (shadow_count == 0) ? ST_EMPTY : ST_OK;
    endcase
    r.count = shadow_count[8:0];
    return r;
  endfunction

  // Valid stays up after a transaction until a later call with a nonzero gap or a drain lowers it.
  task automatic send_request(req_e req, logic [15:0] v, logic [31:0] c);
    int unsigned gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {c, v, req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_heap_request(req, v, c));
    if (req == REQ_INSERT) inserted_vertices.push_back(v);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [8:0] value);
    wait_drained();
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_capacity = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_heap();
    while (shadow_count > 0) send_request(REQ_DELMIN, 16'h0, 32'h0);
  endtask

  // Ready draws its own wait before every transaction, with runs of no stall.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    heap_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[58:0];
      if (pending_results.size() == 0) begin
        $error("result transaction with no request pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.vertex !== want.vertex) begin
          $error("out_vertex: expected %0d, got %0d", want.vertex, got.vertex);
          error_count++;
        end
        if (got.cost !== want.cost) begin
          $error("out_cost: expected %0d, got %0d", want.cost, got.cost);
          error_count++;
        end
        if (got.count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, got.count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[min_heap_priority_queue_core] ERROR");
      $finish;
    end
  end

  task automatic test_empty_cases();
    send_request(REQ_QUERY, 16'h0, 32'h0);
    send_request(REQ_DELMIN, 16'hffff, 32'hffffffff);
    send_request(REQ_DECREASE, 16'h1234, 32'h5);
  endtask

  task automatic test_directed_ops();
    send_request(REQ_INSERT, 16'hffff, 32'hffffffff);
    send_request(REQ_INSERT, 16'h0000, 32'h0);
    send_request(REQ_INSERT, 16'h0007, 32'h100);
    send_request(REQ_INSERT, 16'h0007, 32'h100);  // duplicate vertex, equal cost
    send_request(REQ_INSERT, 16'h0009, 32'h80);
    send_request(REQ_QUERY, 16'h0, 32'h0);
    send_request(REQ_DECREASE, 16'h0007, 32'h10);
    send_request(REQ_DECREASE, 16'h0009, 32'hfffffff0);  // larger cost stays in place
    send_request(REQ_DECREASE, 16'h4444, 32'h1);
    send_request(REQ_DECREASE, 16'hffff, 32'h0);  // ties with root, must not pass it
    drain_heap();
    send_request(REQ_QUERY, 16'h0, 32'h0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(9'd1);
    send_request(REQ_INSERT, 16'h5555, 32'h55);
    send_request(REQ_INSERT, 16'haaaa, 32'haa);
    write_capacity(9'd0);
    send_request(REQ_INSERT, 16'h1, 32'h1);
    send_request(REQ_DELMIN, 16'h0, 32'h0);
    write_capacity(9'd511);
    repeat (5) send_request(REQ_INSERT, 16'($urandom), $urandom);
    write_capacity(9'd3);  // lowered below the current count
    send_request(REQ_INSERT, 16'h2, 32'h2);
    drain_heap();
  endtask

  task automatic random_phase(int unsigned items, int unsigned fill_bias);
    int unsigned pick;
    logic [15:0] v;
    logic [31:0] c;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      c = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : 32'($urandom);
      v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 31)) : 16'($urandom);
      if (pick < fill_bias) send_request(REQ_INSERT, v, c);
      else if (pick < fill_bias + 25) send_request(REQ_DELMIN, v, c);
      else if (pick < fill_bias + 40) begin
        if (inserted_vertices.size() != 0 && $urandom_range(0, 3) != 0)
          v = 16'(inserted_vertices[$urandom_range(0, inserted_vertices.size() - 1)]);
        send_request(REQ_DECREASE, v, c);
      end else send_request(REQ_QUERY, v, c);
    end
  endtask

  task automatic test_random_traffic();
    write_capacity(9'd256);
    random_phase(60, 45);
    write_capacity(9'd256);
    random_phase(270, 100);  // inserts only, fills the heap to its full depth
    write_capacity(9'd5);
    random_phase(40, 40);
    write_capacity(9'd300);
    random_phase(50, 30);
  endtask

  initial begin
    shadow_count = 0;
    shadow_capacity = 256;
    error_count = 0;
    cycle_count = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_cases();
    test_directed_ops();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) $display("[min_heap_priority_queue_core] OK");
    else $display("[min_heap_priority_queue_core] ERROR");
    $finish;
  end

endmodule
